### hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, codes and the sextet-to-character mapping shared by the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
		logic       message_done;
	} char_item_t;

	// one input byte: up to two sextets, then '=' padding up to last_idx
	typedef struct packed {
		logic [5:0] sx0;
		logic [5:0] sx1;
		logic [1:0] last_idx;
		logic       done;
	} job_t;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} queue_status_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

### hdl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group phase and leftover bits, and turns
// each byte into a character job for the back end.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  b64e_pkg::byte_item_t   byte_data,
	input  b64e_pkg::queue_status_t q_status,
	output logic                   push,
	output b64e_pkg::job_t         push_job
);
	import b64e_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [3:0] left_q;
	logic [3:0] left_d;
	logic [7:0] b;
	logic       last;

	assign byte_stall = q_status.full;
	assign push       = byte_valid && !q_status.full;
	assign b          = byte_data.data_byte;
	assign last       = byte_data.end_of_message;

	always_comb begin
		push_job.done = last;
		case (phase_q)
			PH_SECOND: begin
				push_job.sx0      = {left_q[1:0], b[7:4]};
				push_job.sx1      = {b[3:0], 2'b00};
				push_job.last_idx = last ? 2'd2 : 2'd0;
				phase_d           = last ? PH_FIRST : PH_THIRD;
				left_d            = last ? 4'd0 : b[3:0];
			end
			PH_THIRD: begin
				push_job.sx0      = {left_q, b[7:6]};
				push_job.sx1      = b[5:0];
				push_job.last_idx = 2'd1;
				phase_d           = PH_FIRST;
				left_d            = 4'd0;
			end
			default: begin
				push_job.sx0      = b[7:2];
				push_job.sx1      = {b[1:0], 4'b0000};
				push_job.last_idx = last ? 2'd3 : 2'd0;
				phase_d           = last ? PH_FIRST : PH_SECOND;
				left_d            = last ? 4'd0 : {2'b00, b[1:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= 4'd0;
		end else if (push) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

### hdl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry job queue between the front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64e_pkg::job_t          push_job,
	input  logic                    pop,
	output b64e_pkg::job_t          head,
	output b64e_pkg::queue_status_t status
);
	import b64e_pkg::*;

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	job_t            entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head              = entry_q[rd_ptr_q];
	assign status.head_valid = (count_q != '0);
	assign status.full       = (count_q == CntW'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the queue head job into the output register one character per cycle
// unless stalled, mapping sextets to the alphabet and filling in padding.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64e_pkg::job_t          head,
	input  b64e_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    char_valid,
	input  logic                    char_stall,
	output b64e_pkg::char_item_t    char_data
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       char_valid_q;
	char_item_t char_q;
	char_item_t char_d;
	logic       advance;
	logic       emit;
	logic       at_end;

	assign advance    = !char_valid_q || !char_stall;
	assign emit       = advance && q_status.head_valid;
	assign at_end     = (idx_q == head.last_idx);
	assign pop        = emit && at_end;
	assign char_valid = char_valid_q;
	assign char_data  = char_q;

	always_comb begin
		case (idx_q)
			2'd0:    char_d.out_char = sextet_char(head.sx0);
			2'd1:    char_d.out_char = sextet_char(head.sx1);
			default: char_d.out_char = PAD_CHAR;
		endcase
		char_d.last_char    = at_end;
		char_d.message_done = at_end && head.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= 2'd0;
			char_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				char_valid_q <= q_status.head_valid;
			end
			if (pop) begin
				idx_q <= 2'd0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= char_d;
		end
	end

endmodule

### hdl/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming Base64 encoder, standard alphabet with '=' padding.
//
//   channel | direction | fields
//   byte    | in        | data_byte, end_of_message
//   char    | out       | out_char, last_char, message_done
//
// a byte yields one to four characters, one per cycle while char_stall is low
// sustained rate is set by the single character output register
// a two-entry job queue parts the byte side from the character side
// byte_stall rises only while the queue is full
// reset returns the group phase to the start of a group and empties the queue
// ----------------------------------------------------------------------------
module base64_stream_encoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  b64e_pkg::byte_item_t byte_data,
	output logic                 char_valid,
	input  logic                 char_stall,
	output b64e_pkg::char_item_t char_data
);
	import b64e_pkg::*;

	queue_status_t q_status;
	job_t          push_job;
	job_t          head;
	logic          push;
	logic          pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_status   (q_status),
		.push       (push),
		.push_job   (push_job)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule

### tb/sv/tb_base64_stream_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_top
// Self-checking bench for the streaming Base64 encoder. A short table of
// directed bytes, some with hand-typed characters, comes first. Random messages of
// mostly short length follow, checked against an in-bench encoder. Both sides
// get random gaps and stalls, and the byte side holds off until the results
// drain fully at least once.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_top;
	import b64e_pkg::*;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam int TARGET_BYTES = 420;
	localparam int NUM_DIRECTED = 24;
	localparam int MAX_SHOWN = 10;

	// typed holds up to four characters, left aligned; n_typed of zero means predicted
	typedef struct packed {
		logic [7:0]  data;
		logic        eom;
		logic [2:0]  n_typed;
		logic [31:0] typed;
	} vector_t;

	localparam vector_t DIRECTED [0:NUM_DIRECTED-1] = '{
		{8'h00, 1'b1, 3'd4, "AA=="},
		{8'hFF, 1'b1, 3'd4, "/w=="},
		{8'h4D, 1'b0, 3'd1, "T   "},
		{8'h61, 1'b0, 3'd1, "W   "},
		{8'h6E, 1'b0, 3'd2, "Fu  "},
		{8'hFF, 1'b0, 3'd1, "/   "},
		{8'hFF, 1'b1, 3'd3, "/8= "},
		{8'h00, 1'b0, 3'd1, "A   "},
		{8'h00, 1'b0, 3'd1, "A   "},
		{8'h00, 1'b1, 3'd2, "AA  "},
		{8'hFF, 1'b0, 3'd1, "/   "},
		{8'hFF, 1'b0, 3'd1, "/   "},
		{8'hFF, 1'b1, 3'd2, "//  "},
		{8'h80, 1'b1, 3'd4, "gA=="},
		{8'h01, 1'b1, 3'd4, "AQ=="},
		{8'hAA, 1'b0, 3'd0, "    "},
		{8'h55, 1'b1, 3'd0, "    "},
		{8'h55, 1'b0, 3'd0, "    "},
		{8'hAA, 1'b0, 3'd0, "    "},
		{8'h0F, 1'b0, 3'd0, "    "},
		{8'hF0, 1'b1, 3'd0, "    "},
		{8'hFC, 1'b0, 3'd0, "    "},
		{8'h03, 1'b0, 3'd0, "    "},
		{8'h3F, 1'b1, 3'd0, "    "}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_item_t byte_data;
	logic       char_valid;
	logic       char_stall = 1'b0;
	char_item_t char_data;

	phase_t     group_phase;
	logic [3:0] carry_bits;
	char_item_t pending_chars[$];
	int         mismatches = 0;
	int         chars_checked = 0;
	int         bytes_sent = 0;
	int         messages = 0;
	int         ends_in_phase[3] = '{0, 0, 0};
	int         stall_left = 0;
	bit         calm = 1'b0;

	base64_stream_encoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] alpha(input logic [5:0] v);
		return ALPHABET[8*(63-v) +: 8];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// characters of one byte, first one in the low lane
	function automatic int encode_byte(input logic [7:0] b, input logic eom,
			output logic [31:0] chars);
		int n;
		int slot;
		chars = '0;
		case (group_phase)
		PH_SECOND: begin
			slot = 1;
			chars[7:0] = alpha({carry_bits[1:0], b[7:4]});
			n = 1;
			if (eom) begin
				chars[15:8] = alpha({b[3:0], 2'b00});
				chars[23:16] = PAD_CHAR;
				n = 3;
			end
			group_phase = PH_THIRD;
			carry_bits = b[3:0];
		end
		PH_THIRD: begin
			slot = 2;
			chars[7:0] = alpha({carry_bits, b[7:6]});
			chars[15:8] = alpha(b[5:0]);
			n = 2;
			group_phase = PH_FIRST;
			carry_bits = '0;
		end
		default: begin
			slot = 0;
			chars[7:0] = alpha(b[7:2]);
			n = 1;
			if (eom) begin
				chars[15:8] = alpha({b[1:0], 4'b0000});
				chars[23:16] = PAD_CHAR;
				chars[31:24] = PAD_CHAR;
				n = 4;
			end
			group_phase = PH_SECOND;
			carry_bits = {2'b00, b[1:0]};
		end
		endcase
		if (eom) begin
			ends_in_phase[slot]++;
			group_phase = PH_FIRST;
			carry_bits = '0;
		end
		return n;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// one byte transfer, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] d, input logic e, input logic [2:0] n_typed,
			input logic [31:0] typed);
		int gap;
		int n;
		logic [31:0] chars;
		char_item_t item;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= {d, e};
		do begin
			@(posedge clk);
		end while (byte_stall);
		n = encode_byte(d, e, chars);
		if (n_typed != 0) begin
			n = n_typed;
			for (int k = 0; k < 4; k++) begin
				chars[8*k +: 8] = typed[8*(3-k) +: 8];
			end
		end
		for (int k = 0; k < n; k++) begin
			item.out_char = chars[8*k +: 8];
			item.last_char = (k == n - 1);
			item.message_done = e && (k == n - 1);
			pending_chars.insert(pending_chars.size(), item);
		end
		bytes_sent++;
		if (e) begin
			messages++;
		end
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			char_stall <= 1'b1;
			stall_left--;
		end else begin
			char_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_chars
		char_item_t want;
		if (arst_n && char_valid && !char_stall) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected char transfer %h last %b done %b",
					char_data.out_char, char_data.last_char, char_data.message_done));
			end else begin
				want = pending_chars.pop_front();
				if (want.out_char !== char_data.out_char
						|| want.last_char !== char_data.last_char
						|| want.message_done !== char_data.message_done) begin
					report($sformatf("char exp %h/%b/%b got %h/%b/%b (char/last/done)",
						want.out_char, want.last_char, want.message_done,
						char_data.out_char, char_data.last_char, char_data.message_done));
				end
			end
		end
	end

	initial begin
		int len;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		group_phase = PH_FIRST;
		carry_bits = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_byte(DIRECTED[i].data, DIRECTED[i].eom, DIRECTED[i].n_typed,
				DIRECTED[i].typed);
		end

		while (bytes_sent < TARGET_BYTES) begin
			if (messages % 8 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 24);
			for (int j = 1; j <= len; j++) begin
				send_byte(8'($urandom_range(0, 255)), j == len, 3'd0, '0);
			end
			// hold the byte side until every pending character is out
			if (messages == 20 || $urandom_range(0, 9) == 0) begin
				byte_valid <= 1'b0;
				while (pending_chars.size() != 0) begin
					@(posedge clk);
				end
				@(negedge clk);
			end
		end
		byte_valid <= 1'b0;

		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("encoded %0d bytes in %0d messages, %0d characters checked, %0d mismatches",
			bytes_sent, messages, chars_checked, mismatches);
		$display("messages closed in group phase 0/1/2: %0d/%0d/%0d",
			ends_in_phase[0], ends_in_phase[1], ends_in_phase[2]);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d characters pending", pending_chars.size());
		$display("status: fail");
		$finish;
	end

endmodule

### sim.f
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder_top.sv
tb/sv/tb_base64_stream_encoder_top.sv
